// ----- rtl/threshold_command_parser_gate_core_defines.svh -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: assertion macros
// Shared concurrent assertion forms; the using module provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_COMMAND_PARSER_GATE_CORE_DEFINES_SVH
`define THRESHOLD_COMMAND_PARSER_GATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define TCPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: package
// Shared constants, codes and the command / result structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpg_pkg;

	localparam int LINE_LENGTH = 32;
	localparam int POS_W       = $clog2(LINE_LENGTH);
	localparam int HEAD_LEN    = 8;     // bytes of a line that decoding looks at

	localparam int THR_W    = 14;
	localparam int SAMPLE_W = 10;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		ACT_BYTE   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_SWITCH = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		RESP_NONE   = 3'd0,
		RESP_REPORT = 3'd1,
		RESP_SET    = 3'd2,
		RESP_TOGGLE = 3'd3,
		RESP_HELP   = 3'd4
	} resp_t;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_SAMPLE = 3'd1,
		OP_SWITCH = 3'd2,
		OP_REPORT = 3'd3,
		OP_SET    = 3'd4,
		OP_TOGGLE = 3'd5,
		OP_HELP   = 3'd6
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [THR_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		logic             drive;
		resp_t            response;
		logic [THR_W-1:0] value;
		logic             print_on;
	} res_t;

endpackage

// ----- rtl/tcpg_front.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: front end
// Tracks the line position, keeps the head of the line and turns each beat
// into one command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    action,
	input  logic [7:0]                    byte_value,
	input  logic [tcpg_pkg::SAMPLE_W-1:0] sample,
	input  logic                          switch_level,
	output tcpg_pkg::cmd_t                cmd
);
	import tcpg_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       head_q [HEAD_LEN];
	logic [7:0]       eff    [HEAD_LEN];
	logic             line_end;
	logic             is_ask, is_set, is_tog;
	logic             stop, bad;
	logic [THR_W-1:0] acc;
	logic [7:0]       c;
	op_t              line_op;
	logic [THR_W-1:0] line_arg;

	// A line ends on newline or when the last slot is taken; either way the
	// byte at the current position reads as a newline.
	assign line_end = (byte_value == CH_NL) || (pos_q == POS_W'(LINE_LENGTH - 1));

	always_comb begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			eff[i] = (pos_q == POS_W'(i)) ? CH_NL : head_q[i];
		end
	end

	always_comb begin
		is_ask = (eff[0] == CH_R) && (eff[1] == CH_X) && (eff[2] == CH_T)
			&& (eff[3] == CH_QUERY) && (eff[4] == CH_NL);
		is_set = (eff[0] == CH_R) && (eff[1] == CH_X) && (eff[2] == CH_T)
			&& (eff[3] == CH_EQ);
		is_tog = (eff[0] == CH_R) && (eff[1] == CH_X) && (eff[2] == CH_NL);

		// up to four digits after the equals sign
		stop = 1'b0;
		bad  = 1'b0;
		acc  = '0;
		c    = '0;
		for (int k = 0; k < 4; k++) begin
			c = eff[4 + k];
			if (!stop) begin
				if (c == CH_NL) begin
					stop = 1'b1;
				end else if (c < CH_0 || c > CH_9) begin
					bad  = 1'b1;
					stop = 1'b1;
				end else begin
					acc = THR_W'((acc << 3) + (acc << 1) + {{(THR_W-4){1'b0}}, c[3:0]});
				end
			end
		end

		line_arg = '0;
		priority if (is_ask) begin
			line_op = OP_REPORT;
		end else if (is_set) begin
			line_op  = bad ? OP_HELP : OP_SET;
			line_arg = bad ? '0 : acc;
		end else if (is_tog) begin
			line_op = OP_TOGGLE;
		end else begin
			line_op = OP_HELP;
		end
	end

	always_comb begin
		cmd.op  = OP_NONE;
		cmd.arg = '0;
		unique case (act_t'(action))
			ACT_BYTE: begin
				if (line_end) begin
					cmd.op  = line_op;
					cmd.arg = line_arg;
				end
			end
			ACT_SAMPLE: begin
				cmd.op  = OP_SAMPLE;
				cmd.arg = {{(THR_W-SAMPLE_W){1'b0}}, sample};
			end
			ACT_SWITCH: begin
				cmd.op  = OP_SWITCH;
				cmd.arg = {{(THR_W-1){1'b0}}, switch_level};
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && act_t'(action) == ACT_BYTE) begin
			pos_q <= line_end ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			if (accept && act_t'(action) == ACT_BYTE && pos_q == POS_W'(i)) begin
				head_q[i] <= byte_value;
			end
		end
	end

endmodule

// ----- rtl/tcpg_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: command queue
// Small FIFO of decoded commands between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpg_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcpg_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output tcpg_pkg::cmd_t head
);
	import tcpg_pkg::*;
	`include "threshold_command_parser_gate_core_defines.svh"

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`TCPG_ASSERT_NOW(a_fifo_no_overflow, push, !full, "command pushed into a full queue")
	`TCPG_ASSERT_NOW(a_fifo_no_underflow, pop, avail, "command popped from an empty queue")

endmodule

// ----- rtl/tcpg_back.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: back end
// Executes commands against threshold, print flag, switch and sample state
// and holds one result for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcpg_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  tcpg_pkg::cmd_t             cmd,
	output logic                       cmd_take,
	input  logic                       cfg_wr_en,
	input  logic [tcpg_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                       pop,
	output logic                       res_valid,
	output tcpg_pkg::res_t             res
);
	import tcpg_pkg::*;
	`include "threshold_command_parser_gate_core_defines.svh"

	logic [THR_W-1:0]    thr_q, thr_n;
	logic                prt_q, prt_n;
	logic                sw_q, sw_n;
	logic [SAMPLE_W-1:0] smp_q, smp_n;
	logic                out_vld_q;
	res_t                res_q, res_n;
	logic                adv;
	logic                thr_upd;
	logic                res_hold;

	// take a command when the result slot is free or drains this cycle
	assign adv       = cmd_valid && (!out_vld_q || pop);
	assign cmd_take  = adv;
	assign res_valid = out_vld_q;
	assign res       = res_q;

	// threshold may only move on a register write or an executed set
	assign thr_upd  = cfg_wr_en || (adv && cmd.op == OP_SET);
	assign res_hold = out_vld_q && !pop;

	always_comb begin
		thr_n          = thr_q;
		prt_n          = prt_q;
		sw_n           = sw_q;
		smp_n          = smp_q;
		res_n.response = RESP_NONE;
		res_n.value    = '0;
		unique case (cmd.op)
			OP_SAMPLE: smp_n = cmd.arg[SAMPLE_W-1:0];
			OP_SWITCH: sw_n = cmd.arg[0];
			OP_REPORT: begin
				res_n.response = RESP_REPORT;
				res_n.value    = thr_q;
			end
			OP_SET: begin
				thr_n          = cmd.arg;
				res_n.response = RESP_SET;
				res_n.value    = cmd.arg;
			end
			OP_TOGGLE: begin
				prt_n          = ~prt_q;
				res_n.response = RESP_TOGGLE;
				res_n.value    = {{(THR_W-1){1'b0}}, ~prt_q};
			end
			OP_HELP:   res_n.response = RESP_HELP;
			default:   res_n.response = RESP_NONE;
		endcase
		res_n.drive    = sw_n && ({{(THR_W-SAMPLE_W){1'b0}}, smp_n} >= thr_n);
		res_n.print_on = prt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			prt_q     <= 1'b0;
			sw_q      <= 1'b0;
			smp_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end else if (adv) begin
				thr_q <= thr_n;
			end
			if (adv) begin
				prt_q <= prt_n;
				sw_q  <= sw_n;
				smp_q <= smp_n;
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	`TCPG_ASSERT_NEXT(a_thr_hold, !thr_upd, $stable(thr_q), "threshold changed without set or write")
	`TCPG_ASSERT_NEXT(a_res_hold, res_hold, out_vld_q && $stable(res_q), "waiting result changed")

endmodule

// ----- rtl/threshold_command_parser_gate_core.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: top level
// Serial command parser for a threshold, a print flag and a gated drive.
// ----------------------------------------------------------------------------
// Each beat on the push side is a serial byte, a sensor sample or a switch
// level, picked by action, and every beat yields exactly one result beat on
// the pop side, in order. Bytes build a line; newline, or filling all
// LINE_LENGTH slots (last byte taken as newline), ends it and decodes one
// command: RXT? reports the threshold, RXT= with up to four digits sets it
// (no digits sets zero, a non-digit gives help), RX toggles the print flag,
// anything else gives help. drive is high when the switch is closed and the
// last sample is at or above the threshold. cfg_wr_en/cfg_wr_data load the
// threshold directly; write it only while no results are outstanding.
// Throughput is one beat per clock while full is low. A result shows on the pop
// side once its command has been written into the four-entry command queue by
// the accepting edge and then moved through the back end into the result
// register, a move that waits while an earlier result is not popped. full rises
// only when that queue fills because results are not being popped.
`timescale 1ns / 1ps

module threshold_command_parser_gate_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [13:0] cfg_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  byte_value,
	input  logic [9:0]  sample,
	input  logic        switch_level,
	output logic        empty,
	input  logic        pop,
	output logic        drive,
	output logic [2:0]  response,
	output logic [13:0] response_value,
	output logic        print_on
);
	import tcpg_pkg::*;

	logic accept;
	cmd_t front_cmd;
	cmd_t q_head;
	logic q_full;
	logic q_avail;
	logic q_take;
	logic res_valid;
	res_t res;

	assign accept = push && !q_full;
	assign full   = q_full;

	// front: position tracking and line decode
	tcpg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.byte_value   (byte_value),
		.sample       (sample),
		.switch_level (switch_level),
		.cmd          (front_cmd)
	);

	// decouples decode from execution
	tcpg_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_take),
		.avail    (q_avail),
		.head     (q_head)
	);

	// back: state update and result register
	tcpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_avail),
		.cmd         (q_head),
		.cmd_take    (q_take),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pop         (pop),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign empty          = !res_valid;
	assign drive          = res.drive;
	assign response       = res.response;
	assign response_value = res.value;
	assign print_on       = res.print_on;

endmodule

// ----- dv/threshold_command_parser_gate_core_tb.sv -----
// ----------------------------------------------------------------------------
// Threshold command parser gate: testbench
// Runs a table of directed beats and then randomized command lines, sensor
// samples and switch levels through the core. Every result beat is checked
// against a predictor in step with accepted beats, or a typed row's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_command_parser_gate_core_tb;

	import tcpg_pkg::*;

	// Action code the core must ignore: no state change, no response.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [7:0] CH_FILL    = 8'h2E;

	localparam int IDLE_LIMIT     = 2000;  // cycles with no beat on either side
	localparam int RAND_PHASES    = 6;
	localparam int BEATS_PER_PHASE = 200;
	localparam int MAX_PRINTS     = 100;
	localparam int N_DIR          = 26;

	typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_MOSTLY} pop_mode_t;

	// One row of the directed table. A non-empty txt is sent as byte beats;
	// a typed row carries the result of its last beat, read off by hand.
	typedef struct {
		logic [1:0] act;
		string      txt;
		logic [7:0] bval;
		logic [9:0] smp;
		logic       sw;
		bit         typed;
		res_t       want;
	} row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [13:0] cfg_wr_data  = '0;
	logic        push         = 1'b0;
	logic        full;
	logic [1:0]  action       = '0;
	logic [7:0]  byte_value   = '0;
	logic [9:0]  sample       = '0;
	logic        switch_level = 1'b0;
	logic        empty;
	logic        pop          = 1'b0;
	logic        drive;
	logic [2:0]  response;
	logic [13:0] response_value;
	logic        print_on;

	// Tags that travel with the beat on the push side.
	bit          beat_typed = 1'b0;
	res_t        beat_want  = '0;

	// Predictor state
	logic [7:0]  pred_line [LINE_LENGTH] = '{default: '0};
	int          pred_pos    = 0;
	logic [13:0] pred_thr    = '0;
	logic        pred_print  = 1'b0;
	logic        pred_switch = 1'b0;
	logic [9:0]  pred_sample = '0;

	res_t        due_results [$];
	int          n_err       = 0;
	int          n_results   = 0;
	int          n_beats     = 0;
	int          idle_cycles = 0;
	int          burst_left  = 0;
	int          thr_hint    = 0;   // rough threshold, steers samples near the edge

	row_t dir_rows [N_DIR] = '{
		// full line: last slot becomes a newline, no command matches
		'{ACT_BYTE, "ABCDEFGHIJKLMNOPQRSTUVWXYZ012345", 8'h00, 10'd0, 1'b0, 1'b1,
			'{1'b0, RESP_HELP, 14'd0, 1'b0}},
		'{ACT_BYTE, "RXT?\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_REPORT, 14'd9999, 1'b0}},
		'{ACT_BYTE, "RX\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_TOGGLE, 14'd1, 1'b1}},
		// no digits sets zero
		'{ACT_BYTE, "RXT=\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd0, 1'b1}},
		'{ACT_SAMPLE, "", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_NONE, 14'd0, 1'b1}},
		'{ACT_SWITCH, "", 8'h00, 10'd0, 1'b1, 1'b1, '{1'b1, RESP_NONE, 14'd0, 1'b1}},
		'{ACT_BYTE, "RXT=9999\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd9999, 1'b1}},
		'{ACT_SAMPLE, "", 8'h00, 10'd1023, 1'b0, 1'b1, '{1'b0, RESP_NONE, 14'd0, 1'b1}},
		// fifth digit is dropped
		'{ACT_BYTE, "RXT=12345\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd1234, 1'b1}},
		'{ACT_BYTE, "RXT=1023\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b1, RESP_SET, 14'd1023, 1'b1}},
		'{ACT_BYTE, "RXT=1024\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd1024, 1'b1}},
		// non-digit: help, threshold kept
		'{ACT_BYTE, "RXT=5a\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_HELP, 14'd0, 1'b1}},
		'{ACT_BYTE, "RXT?\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_REPORT, 14'd1024, 1'b1}},
		'{ACT_UNUSED, "", 8'hFF, 10'h3FF, 1'b1, 1'b1, '{1'b0, RESP_NONE, 14'd0, 1'b1}},
		'{ACT_BYTE, "rxt?\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_HELP, 14'd0, 1'b1}},
		'{ACT_BYTE, "RX\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_TOGGLE, 14'd0, 1'b0}},
		'{ACT_SWITCH, "", 8'h00, 10'd0, 1'b0, 1'b0, '0},
		'{ACT_BYTE, "", 8'h00, 10'd0, 1'b0, 1'b0, '0},
		'{ACT_BYTE, "", 8'hFF, 10'd0, 1'b0, 1'b0, '0},
		'{ACT_BYTE, "\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_HELP, 14'd0, 1'b0}},
		'{ACT_BYTE, "RXT=00001\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd0, 1'b0}},
		'{ACT_BYTE, "RXT=7\n", 8'h00, 10'd0, 1'b0, 1'b1, '{1'b0, RESP_SET, 14'd7, 1'b0}},
		'{ACT_SWITCH, "", 8'h00, 10'd0, 1'b1, 1'b0, '0},
		'{ACT_SAMPLE, "", 8'h00, 10'd6, 1'b0, 1'b1, '{1'b0, RESP_NONE, 14'd0, 1'b0}},
		'{ACT_SAMPLE, "", 8'h00, 10'd7, 1'b0, 1'b1, '{1'b1, RESP_NONE, 14'd0, 1'b0}},
		// set command that runs into a full line
		'{ACT_BYTE, "RXT=1234567890123456789012345678", 8'h00, 10'd0, 1'b0, 1'b1,
			'{1'b0, RESP_SET, 14'd1234, 1'b0}}
	};

	threshold_command_parser_gate_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.push           (push),
		.full           (full),
		.action         (action),
		.byte_value     (byte_value),
		.sample         (sample),
		.switch_level   (switch_level),
		.empty          (empty),
		.pop            (pop),
		.drive          (drive),
		.response       (response),
		.response_value (response_value),
		.print_on       (print_on)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Decode the gathered line. Only bytes of the current line decide the
	// outcome: every pattern differs from a shorter line before its newline.
	function automatic void decode_pred_line(output resp_t rsp, output logic [13:0] val);
		int         acc;
		bit         stop;
		bit         bad;
		logic [7:0] c;
		acc  = 0;
		stop = 1'b0;
		bad  = 1'b0;
		val  = '0;
		if (pred_line[0] == CH_R && pred_line[1] == CH_X && pred_line[2] == CH_T &&
				pred_line[3] == CH_QUERY && pred_line[4] == CH_NL) begin
			rsp = RESP_REPORT;
			val = pred_thr;
		end else if (pred_line[0] == CH_R && pred_line[1] == CH_X && pred_line[2] == CH_T &&
				pred_line[3] == CH_EQ) begin
			// up to four digits; newline ends early, anything after them is ignored
			for (int k = 0; k < 4; k++) begin
				c = pred_line[4 + k];
				if (!stop) begin
					if (c == CH_NL) begin
						stop = 1'b1;
					end else if (c < CH_0 || c > CH_9) begin
						stop = 1'b1;
						bad  = 1'b1;
					end else begin
						acc = acc * 10 + int'(c - CH_0);
					end
				end
			end
			if (bad) begin
				rsp = RESP_HELP;
			end else begin
				pred_thr = 14'(acc);
				rsp      = RESP_SET;
				val      = pred_thr;
			end
		end else if (pred_line[0] == CH_R && pred_line[1] == CH_X && pred_line[2] == CH_NL) begin
			pred_print = ~pred_print;
			rsp        = RESP_TOGGLE;
			val        = {13'd0, pred_print};
		end else begin
			rsp = RESP_HELP;
		end
	endfunction

	function automatic res_t predict_gate_beat(input logic [1:0] act, input logic [7:0] b,
			input logic [9:0] s, input logic w);
		res_t        r;
		resp_t       rsp;
		logic [13:0] val;
		r   = '0;
		rsp = RESP_NONE;
		val = '0;
		if (act == ACT_BYTE) begin
			if (pred_pos >= LINE_LENGTH)
				pred_pos = 0;
			pred_line[pred_pos] = b;
			pred_pos++;
			if (pred_pos >= LINE_LENGTH || b == CH_NL) begin
				// a full line ends with a forced newline
				if (pred_pos >= LINE_LENGTH)
					pred_line[LINE_LENGTH - 1] = CH_NL;
				decode_pred_line(rsp, val);
				pred_pos = 0;
			end
		end else if (act == ACT_SAMPLE) begin
			pred_sample = s;
		end else if (act == ACT_SWITCH) begin
			pred_switch = w;
		end
		r.drive    = pred_switch && ({4'd0, pred_sample} >= pred_thr);
		r.response = rsp;
		r.value    = val;
		r.print_on = pred_print;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_error(input string msg);
		n_err++;
		if (n_err <= MAX_PRINTS)
			$display("%0t ERROR: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [13:0] got,
			input logic [13:0] want_v);
		if (got !== want_v)
			flag_error($sformatf("result %0d %s: got %0h, want %0h", n_results, name, got,
				want_v));
	endtask

	// Sampled at the edge, before the core's own updates land: push, pop and
	// the fields were set by nonblocking writes at the previous edge.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				pred_thr = cfg_wr_data;
			if (push && !full) begin
				want = predict_gate_beat(action, byte_value, sample, switch_level);
				due_results.push_back(beat_typed ? beat_want : want);
			end
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					flag_error($sformatf("result %0d with nothing expected", n_results));
				end else begin
					want = due_results.pop_front();
					check_field("drive", {13'd0, drive}, {13'd0, want.drive});
					check_field("response", {11'd0, response}, {11'd0, want.response});
					check_field("response_value", response_value, want.value);
					check_field("print_on", {13'd0, print_on}, {13'd0, want.print_on});
				end
				n_results++;
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("watchdog: no beat for %0d cycles, %0d results outstanding", IDLE_LIMIT,
			due_results.size());
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stalls follow a mode that is redrawn after each random run,
	// so the four-entry queue fills and full gets exercised.
	// ------------------------------------------------------------------
	initial begin
		int        run;
		pop_mode_t mode;
		run  = 0;
		mode = POP_ALWAYS;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (run == 0) begin
				mode = pop_mode_t'($urandom_range(0, 3));
				run  = $urandom_range(4, 48);
			end
			run--;
			case (mode)
				POP_ALWAYS: pop <= 1'b1;
				POP_HALF:   pop <= 1'($urandom_range(0, 1));
				POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
				default:    pop <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// One push beat. Bursts of random length, each possibly led by a gap.
	task automatic send_beat(input logic [1:0] a, input logic [7:0] b, input logic [9:0] s,
			input logic w, input bit typed, input res_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push         <= 1'b1;
		action       <= a;
		byte_value   <= b;
		sample       <= s;
		switch_level <= w;
		beat_typed   <= typed;
		beat_want    <= want;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (a != ACT_UNUSED)
			n_beats++;
	endtask

	// Threshold load only with nothing in flight: every beat yields a result,
	// so an empty expectation queue means the core is idle.
	task automatic load_threshold(input logic [13:0] v);
		push <= 1'b0;
		@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_hint = v;
	endtask

	// Sample, switch or ignored beat; samples lean toward the threshold edge.
	task automatic send_sensor();
		int         pick;
		int         t;
		logic [9:0] s;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			send_beat(ACT_UNUSED, 8'($urandom), 10'($urandom), 1'($urandom), 1'b0, '0);
		end else if (pick < 7) begin
			send_beat(ACT_SWITCH, 8'($urandom), 10'($urandom), 1'($urandom), 1'b0, '0);
		end else begin
			case ($urandom_range(0, 9))
				0: s = '0;
				1: s = '1;
				2, 3, 4, 5: begin
					t = thr_hint + $urandom_range(0, 6) - 3;
					s = (t < 0) ? 10'd0 : (t > 1023) ? 10'd1023 : 10'(t);
				end
				default: s = 10'($urandom);
			endcase
			send_beat(ACT_SAMPLE, 8'($urandom), s, 1'($urandom), 1'b0, '0);
		end
	endtask

	// One line (or sensor beats only): mostly well-formed commands with random
	// content, the rest near misses, garbage and full lines; sensor beats mixed in.
	task automatic send_command();
		logic [7:0] q [$];
		logic [7:0] c;
		string      txt;
		int         kind;
		int         v;
		txt  = "";
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: txt = "RXT?";
			2:    txt = "RX";
			3, 4, 5: begin
				txt = "RXT=";
				if ($urandom_range(0, 1)) begin
					v        = $urandom_range(0, 1100);
					thr_hint = v;
					txt      = {txt, $sformatf("%0d", v)};
				end else begin
					repeat ($urandom_range(0, 6))
						txt = {txt, $sformatf("%0d", $urandom_range(0, 9))};
				end
			end
			6: begin
				case ($urandom_range(0, 4))
					0: txt = "";
					1: txt = "R";
					2: txt = "RXT";
					3: txt = "RXX";
					default: txt = "RXT?R";
				endcase
			end
			default: ;
		endcase
		if (kind >= 8) begin
			repeat ($urandom_range(1, 6))
				send_sensor();
		end else begin
			for (int i = 0; i < txt.len(); i++)
				q.push_back(txt[i]);
			if (kind >= 3 && kind <= 5 && $urandom_range(0, 3) == 0)
				q.push_back(8'($urandom_range(58, 255)));   // non-digit
			if (kind == 7) begin
				repeat ($urandom_range(1, 40))
					q.push_back(8'($urandom));
			end
			if (q.size() != 0 && $urandom_range(0, 7) == 0)
				q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				// pad to a full line, no newline of its own
				while (q.size() < LINE_LENGTH) begin
					c = 8'($urandom);
					q.push_back((c == CH_NL) ? CH_FILL : c);
				end
			end else begin
				q.push_back(CH_NL);
			end
			foreach (q[i]) begin
				if ($urandom_range(0, 4) == 0)
					send_sensor();
				send_beat(ACT_BYTE, q[i], 10'($urandom), 1'($urandom), 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [13:0] phase_thr [RAND_PHASES];
		int          goal;
		phase_thr = '{14'd0, 14'h3FFF, 14'($urandom_range(0, 1023)), 14'd9999,
			14'($urandom), 14'($urandom_range(0, 1023))};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. The first row fills every line slot, so nothing
		// undefined is ever decoded afterwards.
		load_threshold(14'd9999);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].act == ACT_BYTE && dir_rows[i].txt.len() != 0) begin
				for (int j = 0; j < dir_rows[i].txt.len(); j++)
					send_beat(ACT_BYTE, dir_rows[i].txt[j], 10'd0, 1'b0,
						dir_rows[i].typed && (j == dir_rows[i].txt.len() - 1),
						dir_rows[i].want);
			end else begin
				send_beat(dir_rows[i].act, dir_rows[i].bval, dir_rows[i].smp, dir_rows[i].sw,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases, each under its own start threshold.
		foreach (phase_thr[p]) begin
			load_threshold(phase_thr[p]);
			goal = n_beats + BEATS_PER_PHASE;
			while (n_beats < goal)
				send_command();
		end

		push <= 1'b0;
		@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		if (n_err == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcpg_pkg.sv
rtl/tcpg_front.sv
rtl/tcpg_cmd_fifo.sv
rtl/tcpg_back.sv
rtl/threshold_command_parser_gate_core.sv
dv/threshold_command_parser_gate_core_tb.sv
